// File: rtl/pixel_depth_expander_clut_unit_macros.svh
// Assertion macros shared by the pixel depth expander RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PIXEL_DEPTH_EXPANDER_CLUT_UNIT_MACROS_SVH
`define PIXEL_DEPTH_EXPANDER_CLUT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define PDXC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pdxc assertion failed");
// Condition that must never be true outside reset.
`define PDXC_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("pdxc forbidden condition seen");
`else
`define PDXC_ASSERT(name, clk, rstn, prop)
`define PDXC_ASSERT_NEVER(name, clk, rstn, cond)
`endif

`endif

// File: rtl/pdxc_pkg.sv
// Shared types, codes and helper functions of the pixel depth expander.
// No dependencies; imported by the front, back and top-level modules.
`timescale 1ns / 1ps

package pdxc_pkg;

  typedef enum logic [2:0] {
    OP_PIXEL = 3'd0,
    OP_CLUT  = 3'd1,
    OP_RED   = 3'd2,
    OP_GREEN = 3'd3,
    OP_BLUE  = 3'd4
  } op_e;

  // Depth codes: log2 of source bits per pixel.
  localparam logic [2:0] MODE_1BPP  = 3'd0;
  localparam logic [2:0] MODE_2BPP  = 3'd1;
  localparam logic [2:0] MODE_4BPP  = 3'd2;
  localparam logic [2:0] MODE_8BPP  = 3'd3;
  localparam logic [2:0] MODE_16BPP = 3'd4;
  localparam logic [2:0] MODE_32BPP = 3'd5;
  localparam logic [2:0] MODE_RESET = MODE_8BPP;

  typedef struct packed {
    op_e         op;
    logic [7:0]  index;
    logic [31:0] data;
  } entry_t;

  // Widen a 5-bit channel to 8 bits by replicating its top bits.
  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  // Pixels held in one 32-bit source word.
  function automatic logic [5:0] pixel_count(input logic [2:0] mode);
    logic [5:0] n;
    n = 6'd0;
    unique case (mode)
      MODE_1BPP:  n = 6'd32;
      MODE_2BPP:  n = 6'd16;
      MODE_4BPP:  n = 6'd8;
      MODE_8BPP:  n = 6'd4;
      MODE_16BPP: n = 6'd2;
      MODE_32BPP: n = 6'd1;
      default:    n = 6'd0;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/pixel_depth_expander_clut_unit.sv
// Pixel depth expander with colour lookup and gamma tables: top level.
// Holds the depth register and joins the front queue to the back part.
// Depends on pdxc_pkg, pdxc_front and pdxc_back.
//
// Usage: the slave stream carries table writes and 32-bit source words; the
// kind of item (opcode) travels in tuser. A pixel word at depth_mode 0..5
// gives 32, 16, 8, 4, 2 or 1 output items, the first pixel from the most
// significant bits, with tlast on the final pixel of the word. Table writes
// and unused opcodes give no output item.
// Throughput: the back part issues one pixel per cycle unless the receiver
// stalls the output register. The table read ports set this figure.
// Path: the first pixel of an accepted word passes through the queue register,
// the table read register and the output register, in that order, before
// m_axis_tvalid rises for it.
// Reset clears the queue, the pipeline valids and sets depth_mode to 8 bpp;
// table contents stay undefined until written. When the receiver stalls the
// output register holds, the pipeline and queue fill, and tready falls once
// the queue is full. The user must write depth_mode through cfg_we_i /
// cfg_wdata_i only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps

module pixel_depth_expander_clut_unit #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,      // depth_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,     // [7:0] table_index, [39:8] payload
  input  logic [2:0]  s_axis_tuser,     // [2:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,     // [31:0] out_pixel
  output logic        m_axis_tlast      // last_of_word
);
  import pdxc_pkg::*;

  logic [2:0] mode_q;
  logic       head_valid;
  entry_t     head;
  logic       pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  pdxc_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_index_i   (s_axis_tdata[7:0]),
    .in_data_i    (s_axis_tdata[39:8]),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  pdxc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_pixel_o  (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// File: rtl/pdxc_front.sv
// Front part of the pixel depth expander: takes input items, drops those that
// do nothing, queues the rest for the back part. Depends on pdxc_pkg, macros.
`timescale 1ns / 1ps
`include "pixel_depth_expander_clut_unit_macros.svh"

module pdxc_front #(
  parameter int QueueDepth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       mode_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       in_op_i,
  input  logic [7:0]       in_index_i,
  input  logic [31:0]      in_data_i,
  output logic             head_valid_o,
  output pdxc_pkg::entry_t head_o,
  input  logic             pop_i
);
  import pdxc_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(QueueDepth);

  entry_t            queue_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              keep;
  logic              push;
  logic              pop;
  entry_t            new_entry;

  // Pixel words at an unused depth and unused opcodes produce nothing.
  always_comb begin
    keep = 1'b0;
    unique case (in_op_i) inside
      OP_PIXEL: keep = (mode_i <= MODE_32BPP);
      OP_CLUT, OP_RED, OP_GREEN, OP_BLUE: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o   = (cnt_q != Full);
  assign push         = in_valid_i && in_ready_o && keep;
  assign pop          = pop_i && head_valid_o;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = queue_q[rd_ptr_q];

  assign new_entry.op    = op_e'(in_op_i);
  assign new_entry.index = in_index_i;
  assign new_entry.data  = in_data_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_entry;
    end
  end

  `PDXC_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > Full)
  `PDXC_ASSERT(a_ptrs_track, clk_i, rst_ni,
               (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))

endmodule

// File: rtl/pdxc_back.sv
// Back part of the pixel depth expander: performs table writes, steps through
// the pixels of each word, reads the tables and drives the output register.
// Depends on pdxc_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "pixel_depth_expander_clut_unit_macros.svh"

module pdxc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       mode_i,
  input  logic             head_valid_i,
  input  pdxc_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      out_pixel_o,
  output logic             out_last_o
);
  import pdxc_pkg::*;

  // Colour table and gamma tables; contents are undefined until written.
  logic [31:0] clut_mem  [256];
  logic [7:0]  red_mem   [256];
  logic [7:0]  green_mem [256];
  logic [7:0]  blue_mem  [256];

  logic        busy_q, busy_d;
  logic [31:0] word_q, word_d;
  logic [5:0]  remain_q, remain_d;

  logic        b_valid_q, b_last_q, b_direct_q;
  logic [31:0] clut_rd_q;
  logic [7:0]  red_rd_q, green_rd_q, blue_rd_q;

  logic        out_valid_q, out_valid_d;
  logic        out_last_q;
  logic [31:0] out_pixel_q;

  logic        advance_out, advance_b;
  logic        head_is_pixel;
  logic        pix_fire, last_pix, tbl_wr;
  logic [31:0] cur_word, next_word;
  logic [5:0]  cur_remain;
  logic [7:0]  clut_addr, red_addr, green_addr, blue_addr;

  assign advance_out   = !out_valid_q || out_ready_i;
  assign advance_b     = !b_valid_q || advance_out;
  assign head_is_pixel = head_valid_i && (head_i.op == OP_PIXEL);

  // The first pixel of a word is taken straight from the queue head; the
  // rest come from the shifted copy held while busy.
  assign cur_word   = busy_q ? word_q : head_i.data;
  assign cur_remain = busy_q ? remain_q : pixel_count(mode_i);
  assign last_pix   = (cur_remain == 6'd1);
  assign pix_fire   = advance_b && (busy_q || head_is_pixel);
  assign pop_o      = !busy_q && head_valid_i && (!head_is_pixel || advance_b);
  assign tbl_wr     = pop_o && !head_is_pixel;

  always_comb begin
    clut_addr = cur_word[31:24];
    next_word = cur_word;
    unique case (mode_i)
      MODE_1BPP: begin
        clut_addr = {7'd0, cur_word[31]};
        next_word = {cur_word[30:0], 1'b0};
      end
      MODE_2BPP: begin
        clut_addr = {6'd0, cur_word[31:30]};
        next_word = {cur_word[29:0], 2'b0};
      end
      MODE_4BPP: begin
        clut_addr = {4'd0, cur_word[31:28]};
        next_word = {cur_word[27:0], 4'b0};
      end
      MODE_8BPP: begin
        next_word = {cur_word[23:0], 8'b0};
      end
      MODE_16BPP: begin
        next_word = {cur_word[15:0], 16'b0};
      end
      default: begin
        next_word = cur_word;
      end
    endcase
  end

  always_comb begin
    if (mode_i == MODE_16BPP) begin
      red_addr   = widen5(cur_word[30:26]);
      green_addr = widen5(cur_word[25:21]);
      blue_addr  = widen5(cur_word[20:16]);
    end else begin
      red_addr   = cur_word[23:16];
      green_addr = cur_word[15:8];
      blue_addr  = cur_word[7:0];
    end
  end

  always_comb begin
    busy_d   = busy_q;
    word_d   = word_q;
    remain_d = remain_q;
    if (pix_fire) begin
      busy_d   = !last_pix;
      word_d   = next_word;
      remain_d = cur_remain - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      remain_q <= '0;
    end else begin
      busy_q   <= busy_d;
      remain_q <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // Table ports: one write and one registered read per table each cycle.
  always_ff @(posedge clk_i) begin
    if (tbl_wr && head_i.op == OP_CLUT) begin
      clut_mem[head_i.index] <= head_i.data;
    end
    if (pix_fire) begin
      clut_rd_q <= clut_mem[clut_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_wr && head_i.op == OP_RED) begin
      red_mem[head_i.index] <= head_i.data[7:0];
    end
    if (pix_fire) begin
      red_rd_q <= red_mem[red_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_wr && head_i.op == OP_GREEN) begin
      green_mem[head_i.index] <= head_i.data[7:0];
    end
    if (pix_fire) begin
      green_rd_q <= green_mem[green_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_wr && head_i.op == OP_BLUE) begin
      blue_mem[head_i.index] <= head_i.data[7:0];
    end
    if (pix_fire) begin
      blue_rd_q <= blue_mem[blue_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (advance_b) begin
      b_valid_q <= pix_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      b_last_q   <= last_pix;
      b_direct_q <= (mode_i >= MODE_16BPP);
    end
  end

  assign out_valid_d = advance_out ? b_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_out && b_valid_q) begin
      out_last_q  <= b_last_q;
      out_pixel_q <= b_direct_q ? {blue_rd_q, green_rd_q, red_rd_q, 8'd0} : clut_rd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign out_last_o  = out_last_q;

  `PDXC_ASSERT(a_busy_remain, clk_i, rst_ni, busy_q |-> (remain_q != '0))
  `PDXC_ASSERT(a_busy_not_32, clk_i, rst_ni, busy_q |-> (mode_i != MODE_32BPP))
  `PDXC_ASSERT_NEVER(a_pop_while_busy, clk_i, rst_ni, pop_o && busy_q)

endmodule
